// ===== hw/rtl/tpi_pkg.sv =====
// Shared types and constants for the trajectory pose interpolator.
`timescale 1ns / 1ps
package tpi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_DIST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HEADING = 3'd4;

    localparam logic [19:0] STALE_DIST_RESET = 20'd50000;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_OLD      = 3'd2;
    localparam logic [2:0] ST_STALE    = 3'd3;
    localparam logic [2:0] ST_FROZEN   = 3'd4;
    localparam logic [2:0] ST_POSE     = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic MODE_LOAD = 1'b0;

    typedef struct packed {
        logic [31:0]        ptime;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } t_point;

    typedef enum logic [17:0] {
        S_IDLE = 18'b000000000000000001,
        S_CRD  = 18'b000000000000000010,
        S_CHK  = 18'b000000000000000100,
        S_SQ1  = 18'b000000000000001000,
        S_SQ2  = 18'b000000000000010000,
        S_SQ3  = 18'b000000000000100000,
        S_TC0  = 18'b000000000001000000,
        S_TC1  = 18'b000000000010000000,
        S_TC2  = 18'b000000000100000000,
        S_SA   = 18'b000000001000000000,
        S_SB   = 18'b000000010000000000,
        S_SRCH = 18'b000000100000000000,
        S_FA   = 18'b000001000000000000,
        S_FB   = 18'b000010000000000000,
        S_FC   = 18'b000100000000000000,
        S_PS   = 18'b001000000000000000,
        S_ITER = 18'b010000000000000000,
        S_LERP = 18'b100000000000000000
    } t_state;

endpackage

// ===== hw/rtl/trajectory_pose_interpolator.sv =====
// Top level: banked point memory, commit checks and tick interpolation sequencer.
`timescale 1ns / 1ps
// Trajectory pose interpolator.
// Command channel: an item is taken when start is high and busy is low.
// mode 0 loads one point into the pending bank; the point marked last
// commits the bank (stamp and stale-distance checks). mode 1 is a tick
// that interpolates the pose on the active trajectory.
// Result channel: o_valid strobes for one cycle with status, the pose and
// the target time; the receiver cannot stall it.
// Config: i_cfg_we / i_cfg_idx / i_cfg_wdata, to be written only while idle
// by the user; the block does not enforce it. A stored, overflowing or
// non-last point, a frozen tick and a tick on a table of two points or
// fewer are answered from idle. A commit steps through S_CRD, S_CHK and
// S_SQ1..S_SQ3. A tick on n > 2 points walks the point memory (one read
// per cycle), then the 17-step ratio divider and two bit-serial square roots.
// One item is worked at a time; busy is high while a commit or long tick runs.
// Reset: empty banks, no trajectory, pose at zero; no clearing pass.
module trajectory_pose_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic [31:0]                    i_pt_time,
    input  logic signed [31:0]             i_pt_x,
    input  logic signed [31:0]             i_pt_y,
    input  logic signed [15:0]             i_pt_heading,
    input  logic signed [15:0]             i_pt_vx,
    input  logic signed [15:0]             i_pt_vy,
    input  logic                           i_last_point,
    input  logic [31:0]                    i_msg_stamp,
    input  logic [31:0]                    i_now_time,
    input  logic                           i_cfg_we,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpi_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic signed [31:0]             o_out_x,
    output logic signed [31:0]             o_out_y,
    output logic signed [15:0]             o_out_heading,
    output logic [15:0]                    o_out_speed,
    output logic [31:0]                    o_target_time
);

    localparam int DEPTH = 2 * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int PW    = $bits(tpi_pkg::t_point);

    // point memory, both banks
    logic [PW-1:0]    mem [DEPTH];
    tpi_pkg::t_point  r_rdata;
    logic [AW-1:0]    w_raddr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    tpi_pkg::t_point  w_wdata;

    tpi_pkg::t_state  r_state;
    logic             r_bank;
    logic [CW-1:0]    r_acount;
    logic [CW-1:0]    r_lcount;
    logic [31:0]      r_fpt;
    logic [31:0]      r_arr;
    logic             r_have;
    logic [31:0]      r_start_time;
    logic [19:0]      r_stale;
    logic signed [31:0] r_pose_x;
    logic signed [31:0] r_pose_y;
    logic signed [15:0] r_pose_h;
    logic [15:0]      r_pose_s;

    logic             r_valid;
    logic [2:0]       r_status;
    logic [31:0]      r_target;

    logic [31:0]      r_stamp;
    logic [31:0]      r_now;
    logic [31:0]      r_t;
    logic [31:0]      r_t0;
    logic             r_far;
    logic [19:0]      r_dx;
    logic [19:0]      r_dy;
    logic [40:0]      r_acc;

    logic [31:0]      r_prev;
    logic [CW-1:0]    r_j;
    logic [CW-1:0]    r_idx;
    tpi_pkg::t_point  r_ea;
    tpi_pkg::t_point  r_eb;
    logic [1:0]       r_pc;
    logic [31:0]      r_va;
    logic [31:0]      r_vb;
    logic [31:0]      r_resa;
    logic [31:0]      r_resb;
    logic [30:0]      r_bit;
    logic [4:0]       r_it;
    logic [32:0]      r_rem;
    logic [31:0]      r_den;
    logic [16:0]      r_q;
    logic             r_rzero;
    logic [2:0]       r_li;
    logic signed [50:0] r_prod;

    logic [AW-1:0]    w_abase;
    logic [AW-1:0]    w_pbase;
    logic             w_accept;
    logic signed [33:0] w_tsum;
    logic [31:0]      w_tsat;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [32:0]      w_adx;
    logic [32:0]      w_ady;
    logic [CW-1:0]    w_jrd;
    logic             w_found;
    logic [31:0]      w_num;
    logic [31:0]      w_den;
    logic signed [15:0] w_sqop;
    logic signed [31:0] w_sq;
    logic [31:0]      w_suma;
    logic [31:0]      w_sumb;
    logic [32:0]      w_rdiff;
    logic [15:0]      w_spa;
    logic [15:0]      w_spb;
    logic [16:0]      w_ratio;
    logic signed [32:0] w_la;
    logic signed [32:0] w_lb;
    logic signed [32:0] w_wa;
    logic signed [50:0] w_rnd;
    logic signed [50:0] w_lres;

    assign w_abase  = r_bank ? AW'(MAX_POINTS) : '0;
    assign w_pbase  = r_bank ? '0 : AW'(MAX_POINTS);
    assign busy     = (r_state != tpi_pkg::S_IDLE);
    assign w_accept = start && !busy;

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_x       = r_pose_x;
    assign o_out_y       = r_pose_y;
    assign o_out_heading = r_pose_h;
    assign o_out_speed   = r_pose_s;
    assign o_target_time = r_target;

    // point write on a load that fits
    assign w_we    = w_accept && (i_mode == tpi_pkg::MODE_LOAD) && (r_lcount < CW'(MAX_POINTS));
    assign w_waddr = w_pbase + AW'(r_lcount);
    assign w_wdata = '{ptime: i_pt_time, x: i_pt_x, y: i_pt_y, heading: i_pt_heading,
                       vx: i_pt_vx, vy: i_pt_vy};

    assign w_jrd = (r_j < r_acount) ? r_j : '0;

    always_comb begin
        case (r_state)
            tpi_pkg::S_CRD:  w_raddr = w_pbase;
            tpi_pkg::S_TC0:  w_raddr = w_abase;
            tpi_pkg::S_TC1:  w_raddr = w_abase + AW'(r_acount - CW'(1));
            tpi_pkg::S_SA:   w_raddr = w_abase;
            tpi_pkg::S_SB:   w_raddr = w_abase + AW'(1);
            tpi_pkg::S_SRCH: w_raddr = w_abase + AW'(w_jrd);
            tpi_pkg::S_FA:   w_raddr = w_abase + AW'(r_idx);
            tpi_pkg::S_FB:   w_raddr = w_abase + AW'(r_idx) + AW'(1);
            default:         w_raddr = w_abase;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= tpi_pkg::t_point'(mem[w_raddr]);
    end

    // target = first time + now - arrival, saturated to 32 bits
    assign w_tsum = $signed({2'b00, r_fpt}) + $signed({2'b00, i_now_time})
                  - $signed({2'b00, r_arr});
    assign w_tsat = w_tsum[33] ? 32'd0 : (w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0]);

    // stale check on point 0 of the pending bank
    assign w_dx  = $signed({r_rdata.x[31], r_rdata.x}) - $signed({r_pose_x[31], r_pose_x});
    assign w_dy  = $signed({r_rdata.y[31], r_rdata.y}) - $signed({r_pose_y[31], r_pose_y});
    assign w_adx = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ady = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);

    assign w_found = (r_prev <= r_t) && (r_rdata.ptime >= r_t);

    // ratio numerator held in [0, t1 - t0]
    assign w_den = r_rdata.ptime - r_ea.ptime;
    assign w_num = (r_t < r_ea.ptime) ? 32'd0 :
                   (((r_t - r_ea.ptime) > w_den) ? w_den : (r_t - r_ea.ptime));

    always_comb begin
        case (r_pc)
            2'd0:    w_sqop = r_ea.vx;
            2'd1:    w_sqop = r_ea.vy;
            2'd2:    w_sqop = r_eb.vx;
            default: w_sqop = r_eb.vy;
        endcase
    end
    assign w_sq = w_sqop * w_sqop;

    assign w_suma  = r_resa + {1'b0, r_bit};
    assign w_sumb  = r_resb + {1'b0, r_bit};
    assign w_rdiff = r_rem - {1'b0, r_den};
    assign w_spa   = r_resa[15:0] + 16'(r_va > r_resa);
    assign w_spb   = r_resb[15:0] + 16'(r_vb > r_resb);
    assign w_ratio = r_rzero ? 17'd0 : r_q;

    // lerp operands: x, y, heading, speed
    always_comb begin
        case (r_li)
            3'd0: begin
                w_la = 33'(r_ea.x);
                w_lb = 33'(r_eb.x);
            end
            3'd1: begin
                w_la = 33'(r_ea.y);
                w_lb = 33'(r_eb.y);
            end
            3'd2: begin
                w_la = 33'(r_ea.heading);
                w_lb = 33'(r_eb.heading);
            end
            default: begin
                w_la = $signed({17'd0, w_spa});
                w_lb = $signed({17'd0, w_spb});
            end
        endcase
    end

    // base value of the lane whose product is registered
    always_comb begin
        case (r_li)
            3'd1:    w_wa = 33'(r_ea.x);
            3'd2:    w_wa = 33'(r_ea.y);
            3'd3:    w_wa = 33'(r_ea.heading);
            default: w_wa = $signed({17'd0, w_spa});
        endcase
    end

    assign w_rnd  = (r_prod + 51'sd32768) >>> 16;
    assign w_lres = 51'(w_wa) + w_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tpi_pkg::S_IDLE;
            r_bank       <= 1'b0;
            r_acount     <= '0;
            r_lcount     <= '0;
            r_fpt        <= '0;
            r_arr        <= '0;
            r_have       <= 1'b0;
            r_start_time <= '0;
            r_stale      <= tpi_pkg::STALE_DIST_RESET;
            r_pose_x     <= '0;
            r_pose_y     <= '0;
            r_pose_h     <= '0;
            r_pose_s     <= '0;
            r_valid      <= 1'b0;
            r_status     <= tpi_pkg::ST_STORED;
            r_target     <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpi_pkg::CFG_START_TIME:   r_start_time <= i_cfg_wdata;
                    tpi_pkg::CFG_STALE_DIST:   r_stale      <= i_cfg_wdata[19:0];
                    tpi_pkg::CFG_INIT_X:       r_pose_x     <= i_cfg_wdata;
                    tpi_pkg::CFG_INIT_Y:       r_pose_y     <= i_cfg_wdata;
                    tpi_pkg::CFG_INIT_HEADING: r_pose_h     <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                tpi_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_stamp <= i_msg_stamp;
                        r_now   <= i_now_time;
                        if (i_mode == tpi_pkg::MODE_LOAD) begin
                            if (r_lcount >= CW'(MAX_POINTS)) begin
                                if (i_last_point) begin
                                    r_lcount <= '0;
                                end
                                r_valid  <= 1'b1;
                                r_status <= tpi_pkg::ST_OVERFLOW;
                                r_target <= '0;
                            end else begin
                                r_lcount <= r_lcount + CW'(1);
                                if (i_last_point) begin
                                    r_state <= tpi_pkg::S_CRD;
                                end else begin
                                    r_valid  <= 1'b1;
                                    r_status <= tpi_pkg::ST_STORED;
                                    r_target <= '0;
                                end
                            end
                        end else if (!r_have) begin
                            r_valid  <= 1'b1;
                            r_status <= tpi_pkg::ST_FROZEN;
                            r_target <= '0;
                        end else if (r_acount > CW'(2)) begin
                            r_t     <= w_tsat;
                            r_state <= tpi_pkg::S_TC0;
                        end else begin
                            r_valid  <= 1'b1;
                            r_status <= tpi_pkg::ST_POSE;
                            r_target <= w_tsat;
                        end
                    end
                end
                tpi_pkg::S_CRD: r_state <= tpi_pkg::S_CHK;
                tpi_pkg::S_CHK: begin
                    r_t0    <= r_rdata.ptime;
                    r_far   <= (w_adx > 33'(r_stale)) || (w_ady > 33'(r_stale));
                    r_dx    <= w_adx[19:0];
                    r_dy    <= w_ady[19:0];
                    r_state <= tpi_pkg::S_SQ1;
                end
                tpi_pkg::S_SQ1: begin
                    r_acc   <= 41'(r_dx * r_dx);
                    r_state <= tpi_pkg::S_SQ2;
                end
                tpi_pkg::S_SQ2: begin
                    r_acc   <= r_acc + 41'(r_dy * r_dy);
                    r_state <= tpi_pkg::S_SQ3;
                end
                tpi_pkg::S_SQ3: begin
                    r_valid  <= 1'b1;
                    r_target <= '0;
                    r_lcount <= '0;
                    r_state  <= tpi_pkg::S_IDLE;
                    if (r_stamp < r_start_time) begin
                        r_status <= tpi_pkg::ST_OLD;
                    end else if (r_far || (r_acc > 41'(r_stale * r_stale))) begin
                        r_status <= tpi_pkg::ST_STALE;
                    end else begin
                        r_status <= tpi_pkg::ST_ACCEPTED;
                        r_bank   <= !r_bank;
                        r_acount <= r_lcount;
                        r_fpt    <= r_t0;
                        r_arr    <= r_now;
                        r_have   <= 1'b1;
                    end
                end
                tpi_pkg::S_TC0: r_state <= tpi_pkg::S_TC1;
                tpi_pkg::S_TC1: begin
                    if (r_t < r_rdata.ptime) begin
                        r_t <= r_rdata.ptime;
                    end
                    r_state <= tpi_pkg::S_TC2;
                end
                tpi_pkg::S_TC2: begin
                    if (r_t > r_rdata.ptime) begin
                        r_t <= r_rdata.ptime;
                    end
                    r_state <= tpi_pkg::S_SA;
                end
                tpi_pkg::S_SA: r_state <= tpi_pkg::S_SB;
                tpi_pkg::S_SB: begin
                    r_prev  <= r_rdata.ptime;
                    r_j     <= CW'(2);
                    r_state <= tpi_pkg::S_SRCH;
                end
                tpi_pkg::S_SRCH: begin
                    // read data is time[j-1], r_prev is time[j-2]
                    if (w_found) begin
                        r_idx   <= r_j - CW'(2);
                        r_state <= tpi_pkg::S_FA;
                    end else if (r_j == r_acount) begin
                        r_idx   <= '0;
                        r_state <= tpi_pkg::S_FA;
                    end else begin
                        r_prev <= r_rdata.ptime;
                        r_j    <= r_j + CW'(1);
                    end
                end
                tpi_pkg::S_FA: r_state <= tpi_pkg::S_FB;
                tpi_pkg::S_FB: begin
                    r_ea    <= r_rdata;
                    r_state <= tpi_pkg::S_FC;
                end
                tpi_pkg::S_FC: begin
                    r_eb    <= r_rdata;
                    r_rzero <= (r_rdata.ptime <= r_ea.ptime);
                    r_den   <= w_den;
                    r_rem   <= {1'b0, w_num};
                    r_q     <= '0;
                    r_resa  <= '0;
                    r_resb  <= '0;
                    r_pc    <= '0;
                    r_state <= tpi_pkg::S_PS;
                end
                tpi_pkg::S_PS: begin
                    case (r_pc)
                        2'd0:    r_va <= w_sq;
                        2'd1:    r_va <= r_va + w_sq;
                        2'd2:    r_vb <= w_sq;
                        default: r_vb <= r_vb + w_sq;
                    endcase
                    r_pc <= r_pc + 2'd1;
                    if (r_pc == 2'd3) begin
                        r_bit   <= 31'h4000_0000;
                        r_it    <= '0;
                        r_state <= tpi_pkg::S_ITER;
                    end
                end
                tpi_pkg::S_ITER: begin
                    // one quotient bit per cycle
                    if (!w_rdiff[32]) begin
                        r_rem <= {w_rdiff[31:0], 1'b0};
                        r_q   <= {r_q[15:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], 1'b0};
                        r_q   <= {r_q[15:0], 1'b0};
                    end
                    // two square roots, one result bit per cycle
                    if (r_it < 5'd16) begin
                        if (r_va >= w_suma) begin
                            r_va   <= r_va - w_suma;
                            r_resa <= (r_resa >> 1) + {1'b0, r_bit};
                        end else begin
                            r_resa <= r_resa >> 1;
                        end
                        if (r_vb >= w_sumb) begin
                            r_vb   <= r_vb - w_sumb;
                            r_resb <= (r_resb >> 1) + {1'b0, r_bit};
                        end else begin
                            r_resb <= r_resb >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'd16) begin
                        r_li    <= '0;
                        r_state <= tpi_pkg::S_LERP;
                    end
                end
                tpi_pkg::S_LERP: begin
                    // product of lane li, write-back of lane li-1
                    r_prod <= (w_lb - w_la) * $signed({1'b0, w_ratio});
                    case (r_li)
                        3'd1:    r_pose_x <= w_lres[31:0];
                        3'd2:    r_pose_y <= w_lres[31:0];
                        3'd3:    r_pose_h <= w_lres[15:0];
                        3'd4:    r_pose_s <= w_lres[15:0];
                        default: ;
                    endcase
                    r_li <= r_li + 3'd1;
                    if (r_li == 3'd4) begin
                        r_valid  <= 1'b1;
                        r_status <= tpi_pkg::ST_POSE;
                        r_target <= r_t;
                        r_state  <= tpi_pkg::S_IDLE;
                    end
                end
                default: r_state <= tpi_pkg::S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/tpi_checker.sv =====
// Port-level checker for the trajectory pose interpolator, with its bind.
`timescale 1ns / 1ps
module tpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [31:0] o_target_time
);

    // a result never shows while an item is still in work
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // busy only rises after a taken command
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without start");

    // a long item ends with its result
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid) else $error("busy dropped without result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 3'd7)) else $error("bad status");

    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tpi_pkg::ST_POSE) |-> (o_target_time == 32'd0))
        else $error("target on non-pose result");

endmodule

bind trajectory_pose_interpolator tpi_checker u_tpi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_target_time (o_target_time)
);
